// File: design/bmc_pkg.sv
// ----------------------------------------------------------------------------
// bmc_pkg
// Shared types and constants for the binary cross-morphology filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_OP_MODE      = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam int unsigned CFG_AW = 2;
    localparam int unsigned CFG_DW = 13;

    localparam int unsigned IMG_W_BITS = 11;
    localparam int unsigned IMG_H_BITS = 13;

    localparam logic [IMG_W_BITS-1:0] IMG_W_RST = 11'd640;
    localparam logic [IMG_H_BITS-1:0] IMG_H_RST = 13'd480;

    // result field widths
    localparam int unsigned OUT_COL_W = 10;
    localparam int unsigned OUT_ROW_W = 12;

    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    // one line buffer entry: same column of the two previous rows
    typedef struct packed {
        logic mid;      // row one above the input
        logic above;    // row two above the input
    } t_lb_entry;

endpackage

`default_nettype wire

// File: design/bmc_linebuf.sv
// ----------------------------------------------------------------------------
// bmc_linebuf
// Two-row line buffer, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_linebuf
    import bmc_pkg::*;
#(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic      i_clk,
    input  wire logic      i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_lb_entry i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output t_lb_entry      o_rdata
);

    t_lb_entry mem [DEPTH];
    t_lb_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/binary_morphology_cross.sv
// ----------------------------------------------------------------------------
// binary_morphology_cross
// Streaming 3x3 binary erosion / dilation with a 4-connected cross.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                      handshake
//  s (pixel) in   tdata[0] pixel_in                            tvalid/tready
//  m (result)out  tdata[0] pixel_out, [10:1] out_col,          tvalid/tready
//                 [22:11] out_row; tlast frame_last
//  cfg       in   addr: 0 op_mode, 1 image_width, 2 image_height  we only
//
//  One pixel per cycle unless the output stalls; an accepted interior word's
//  result is in the output register in the next cycle. The line buffer is
//  read one column ahead to hide its registered read; write and read never
//  hit the same column in the same cycle. A stalled output stops the input only
//  while the output register is full. Synchronous reset clears counters,
//  window and output valid and loads config defaults, not the line buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_morphology_cross
    import bmc_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // pixel word: [0] pixel_in
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [7:0]        i_s_tdata,
    // result word: [0] pixel_out, [10:1] out_col, [22:11] out_row
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [23:0]            o_m_tdata,
    output logic                   o_m_tlast,
    // configuration
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_AW-1:0] i_cfg_addr,
    input  wire logic [CFG_DW-1:0] i_cfg_wdata
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);

    logic                  r_op_mode;
    logic [IMG_W_BITS-1:0] r_img_w;
    logic [IMG_H_BITS-1:0] r_img_h;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [3:0]    r_win, n_win;     // 3 south, 2 north, 1 west, 0 centre

    logic          r_out_valid;
    logic [22:0]   r_out_data;
    logic          r_out_last;

    logic [31:0]   w_eff, h_eff, col_m1, row_m1;
    logic [CW-1:0] last_col;
    logic [RW-1:0] last_row;
    logic          col_end, row_end, s_accept, interior, cross_val, pix;
    logic [CW-1:0] rd_addr;
    t_lb_entry     lb_rd, lb_wr;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_mode <= MODE_ERODE;
            r_img_w   <= IMG_W_RST;
            r_img_h   <= IMG_H_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_OP_MODE:      r_op_mode <= i_cfg_wdata[0];
                CFG_IMAGE_WIDTH:  r_img_w   <= i_cfg_wdata[IMG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: r_img_h   <= i_cfg_wdata[IMG_H_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp sizes to [3, MAX]
    always_comb begin
        if (32'(r_img_w) < 32'd3)              w_eff = 32'd3;
        else if (32'(r_img_w) > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
        else                                    w_eff = 32'(r_img_w);
        if (32'(r_img_h) < 32'd3)               h_eff = 32'd3;
        else if (32'(r_img_h) > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);
        else                                     h_eff = 32'(r_img_h);
    end

    assign last_col = CW'(w_eff - 32'd1);
    assign last_row = RW'(h_eff - 32'd1);

    // ---------------- datapath ----------------
    assign o_s_tready = i_rst_n && (!r_out_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign pix        = i_s_tdata[0];

    assign col_end  = r_col >= last_col;
    assign row_end  = r_row >= last_row;
    assign interior = (r_col >= CW'(2)) && (r_row >= RW'(2));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + RW'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    // east neighbor comes straight from the buffer read
    always_comb begin
        if (r_op_mode == MODE_DILATE) cross_val = (|r_win) | lb_rd.mid;
        else                          cross_val = (&r_win) & lb_rd.mid;
    end

    assign n_win = {pix, lb_rd.above, r_win[0], lb_rd.mid};

    assign lb_wr.mid   = pix;
    assign lb_wr.above = lb_rd.mid;

    // prefetch the column of the next word
    assign rd_addr = !i_rst_n ? '0 : (s_accept ? n_col : r_col);

    bmc_linebuf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_we    (s_accept),
        .i_waddr (r_col),
        .i_wdata (lb_wr),
        .i_raddr (rd_addr),
        .o_rdata (lb_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_win <= '0;
        end else if (s_accept) begin
            r_col <= n_col;
            r_row <= n_row;
            r_win <= n_win;
        end
    end

    assign col_m1 = 32'(r_col) - 32'd1;
    assign row_m1 = 32'(r_row) - 32'd1;

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= interior;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && interior) begin
            r_out_data <= {row_m1[OUT_ROW_W-1:0], col_m1[OUT_COL_W-1:0], cross_val};
            r_out_last <= col_end && row_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_data};
    assign o_m_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    a_interior_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && interior |=> r_out_valid)
        else $error("interior word gave no result");

    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && col_end && row_end |=> (r_col == '0) && (r_row == '0))
        else $error("counters did not return to zero at frame end");

    a_border_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && !interior |=> !r_out_valid)
        else $error("border word produced a result");
`endif

endmodule

`default_nettype wire
